/* rtl/core/assert_macros.svh */
// assertion macros used by the extractor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

/* rtl/core/cpve_pkg.sv */
// types, codes and helpers of the can payload value extractor
`timescale 1ns / 1ps
`default_nettype none
package cpve_pkg;

	localparam int MAX_BYTES    = 8;
	localparam int VAL_W        = 64;
	localparam int LEN_W        = 4;
	localparam int OP_W         = 3;
	localparam int SLOT_IDX_W   = 3;
	localparam int ERR_SLOT_W   = 2;
	localparam int NUM_ARG_REGS = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int CODES_W      = OP_W * NUM_ARG_REGS;

	localparam logic [CFG_IDX_W-1:0] REG_OP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OP_CODES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ARG0     = 3'd2;

	typedef enum logic [OP_W-1:0] {
		OP_SELECT = 3'd0,
		OP_GAIN   = 3'd1,
		OP_OR     = 3'd2,
		OP_AND    = 3'd3,
		OP_SHR    = 3'd4,
		OP_SHL    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_RANGE = 2'd1,
		ERR_WIDTH = 2'd2
	} err_t;

	typedef struct packed {
		logic [VAL_W-1:0]      val;
		logic [LEN_W-1:0]      len;
		err_t                  err;
		logic [ERR_SLOT_W-1:0] err_slot;
	} item_t;

	// ones in the low n bytes
	function automatic logic [VAL_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
		logic [VAL_W-1:0] m;
		for (int i = 0; i < MAX_BYTES; i++) begin
			m[i*8 +: 8] = (LEN_W'(i) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/cpve_ifs.sv */
// request channels of the extractor: frame in, result out, config write
`timescale 1ns / 1ps
`default_nettype none
interface cpve_in_if;
	import cpve_pkg::*;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] frame_bytes;
	logic [LEN_W-1:0] frame_length;
	modport source (output valid, output frame_bytes, output frame_length, input ready);
	modport sink (input valid, input frame_bytes, input frame_length, output ready);
endinterface

interface cpve_out_if;
	import cpve_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [VAL_W-1:0]      result_value;
	logic [LEN_W-1:0]      result_length;
	logic [1:0]            error_code;
	logic [ERR_SLOT_W-1:0] error_slot;
	modport source (output valid, output result_value, output result_length,
		output error_code, output error_slot, input ready);
	modport sink (input valid, input result_value, input result_length,
		input error_code, input error_slot, output ready);
endinterface

interface cpve_cfg_if;
	import cpve_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [VAL_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/cpve_slot.sv */
// one operation slot: decode and apply, partial products, gain sum
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cpve_slot #(
	parameter int SLOT = 0
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       adv,
	input  wire logic                                       in_valid,
	input  cpve_pkg::item_t                                 in_item,
	input  cpve_pkg::op_t                                   op,
	input  wire logic [cpve_pkg::VAL_W-1:0]                 arg,
	input  wire logic [cpve_pkg::SLOT_IDX_W-1:0]            op_count,
	output logic                                            out_valid,
	output cpve_pkg::item_t                                 out_item
);
	import cpve_pkg::*;

	localparam logic [SLOT_IDX_W-1:0] SLOT_IDX = SLOT_IDX_W'(SLOT);
	localparam int HALF_W = VAL_W / 2;

	logic             active;
	logic             width_ok;
	logic             big_shift;
	logic [7:0]       sel_st;
	logic [7:0]       sel_en;
	logic [LEN_W-1:0] sel_len;
	logic [VAL_W-1:0] cur_mask;
	item_t            nxt_item;
	logic             nxt_gain;

	logic             valid_s1;
	item_t            item_s1;
	logic             gain_s1;
	logic [VAL_W-1:0] arg_s1;

	logic              valid_s2;
	item_t             item_s2;
	logic              gain_s2;
	logic [VAL_W-1:0]  p_ll_s2;
	logic [HALF_W-1:0] p_lh_s2;
	logic [HALF_W-1:0] p_hl_s2;

	logic [HALF_W-1:0] cross_sum;
	logic [VAL_W-1:0]  gain_val;

	logic  valid_s3;
	item_t item_s3;

	assign active   = (op_count > SLOT_IDX) && (in_item.err == ERR_NONE);
	assign sel_st   = arg[7:0];
	assign sel_en   = arg[15:8];
	assign sel_len  = LEN_W'(sel_en - sel_st);
	assign cur_mask = byte_mask(in_item.len);
	assign width_ok = (in_item.len == 4'd1) || (in_item.len == 4'd2) ||
		(in_item.len == 4'd4) || (in_item.len == 4'd8);
	assign big_shift = (arg[VAL_W-1:7] != '0) || (arg[6:0] >= {in_item.len, 3'b000});

	// stage one: range and width checks, all ops but the gain product
	always_comb begin
		nxt_item = in_item;
		nxt_gain = 1'b0;
		if (active) begin
			if (op == OP_SELECT) begin
				if ((sel_st > sel_en) || (sel_en > {4'b0000, in_item.len})) begin
					nxt_item.err = ERR_RANGE;
				end else begin
					nxt_item.len = sel_len;
					nxt_item.val = (in_item.val >> {sel_st[3:0], 3'b000}) &
						byte_mask(sel_len);
				end
			end else if (op == OP_GAIN || op == OP_OR || op == OP_AND ||
				op == OP_SHR || op == OP_SHL) begin
				if (!width_ok) begin
					nxt_item.err = ERR_WIDTH;
				end else begin
					unique case (op)
						OP_GAIN: nxt_gain = 1'b1;
						OP_OR:   nxt_item.val = (in_item.val | arg) & cur_mask;
						OP_AND:  nxt_item.val = in_item.val & arg & cur_mask;
						OP_SHR:  nxt_item.val = big_shift ? '0 :
							((in_item.val >> arg[5:0]) & cur_mask);
						OP_SHL:  nxt_item.val = big_shift ? '0 :
							((in_item.val << arg[5:0]) & cur_mask);
						default: nxt_item.val = in_item.val;
					endcase
				end
			end
			if (nxt_item.err != ERR_NONE) begin
				nxt_item.val      = '0;
				nxt_item.len      = '0;
				nxt_item.err_slot = SLOT_IDX[ERR_SLOT_W-1:0];
			end
		end
	end

	// stage three: assemble the truncated 64-bit product
	assign cross_sum = p_lh_s2 + p_hl_s2;
	assign gain_val  = (p_ll_s2 + {cross_sum, {HALF_W{1'b0}}}) & byte_mask(item_s2.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= nxt_item;
			gain_s1 <= nxt_gain;
			arg_s1  <= arg;

			item_s2 <= item_s1;
			gain_s2 <= gain_s1;
			p_ll_s2 <= VAL_W'(item_s1.val[HALF_W-1:0]) * VAL_W'(arg_s1[HALF_W-1:0]);
			p_lh_s2 <= item_s1.val[HALF_W-1:0] * arg_s1[VAL_W-1:HALF_W];
			p_hl_s2 <= item_s1.val[VAL_W-1:HALF_W] * arg_s1[HALF_W-1:0];

			item_s3.len      <= item_s2.len;
			item_s3.err      <= item_s2.err;
			item_s3.err_slot <= item_s2.err_slot;
			item_s3.val      <= gain_s2 ? gain_val : item_s2.val;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

	`ASSERT_IMPLIES(a_err_clears, clk, arst_n, valid_s3 && (item_s3.err != ERR_NONE),
		(item_s3.val == '0) && (item_s3.len == '0))
	`ASSERT_IMPLIES(a_len_range, clk, arst_n, valid_s3, item_s3.len <= 4'd8)
	`ASSERT_IMPLIES(a_slot_clean, clk, arst_n, valid_s3 && (item_s3.err == ERR_NONE),
		item_s3.err_slot == '0)
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, !adv, $stable(valid_s3) && $stable(item_s3))
	`ASSERT_IMPLIES(a_gain_ok, clk, arst_n, valid_s1 && gain_s1,
		item_s1.err == ERR_NONE)

endmodule
`default_nettype wire

/* rtl/core/can_payload_value_extractor.sv */
// top level of the can payload value extractor
// one frame per cycle while not stalled; every slot is three stages, the gain product
//   is split into 32x32 partial products in the middle stage
// a stalled result holds the whole pipeline in place, nothing is dropped
// reset clears all valid bits and all config registers to zero
`timescale 1ns / 1ps
`default_nettype none
module can_payload_value_extractor #(
	parameter int NUM_SLOTS = 4
) (
	input wire logic    clk,
	input wire logic    arst_n,
	cpve_cfg_if.sink    cfg,
	cpve_in_if.sink     frame_in,
	cpve_out_if.source  result_out
);
	import cpve_pkg::*;

	logic [SLOT_IDX_W-1:0] op_count_q;
	logic [CODES_W-1:0]    op_codes_q;
	logic [VAL_W-1:0]      arg_q [NUM_ARG_REGS];

	logic             adv;
	logic [LEN_W-1:0] in_len;
	logic             valid_s0;
	item_t            item_s0;

	logic             chain_valid [NUM_SLOTS+1];
	item_t            chain_item  [NUM_SLOTS+1];
	op_t              slot_op     [NUM_SLOTS];
	logic [VAL_W-1:0] slot_arg    [NUM_SLOTS];

	// config registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_count_q <= '0;
			op_codes_q <= '0;
			for (int i = 0; i < NUM_ARG_REGS; i++) begin
				arg_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			priority if (cfg.index == REG_OP_COUNT) begin
				op_count_q <= cfg.data[SLOT_IDX_W-1:0];
			end else if (cfg.index == REG_OP_CODES) begin
				op_codes_q <= cfg.data[CODES_W-1:0];
			end else if ((cfg.index >= REG_ARG0) &&
				(cfg.index < REG_ARG0 + CFG_IDX_W'(NUM_ARG_REGS))) begin
				arg_q[2'(cfg.index - REG_ARG0)] <= cfg.data;
			end
		end
	end

	// pipeline moves as one whenever the output register can take a result
	assign adv            = !chain_valid[NUM_SLOTS] || result_out.ready;
	assign frame_in.ready = adv;

	// input stage: clamp length, drop bytes past it
	assign in_len = (frame_in.frame_length > LEN_W'(MAX_BYTES)) ?
		LEN_W'(MAX_BYTES) : frame_in.frame_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (adv) begin
			valid_s0 <= frame_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s0.val      <= frame_in.frame_bytes & byte_mask(in_len);
			item_s0.len      <= in_len;
			item_s0.err      <= ERR_NONE;
			item_s0.err_slot <= '0;
		end
	end

	assign chain_valid[0] = valid_s0;
	assign chain_item[0]  = item_s0;

	for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
		if (s < NUM_ARG_REGS) begin : g_cfg
			assign slot_op[s]  = op_t'(op_codes_q[OP_W*s +: OP_W]);
			assign slot_arg[s] = arg_q[s];
		end else begin : g_none
			assign slot_op[s]  = OP_SELECT;
			assign slot_arg[s] = '0;
		end

		cpve_slot #(
			.SLOT (s)
		) u_slot (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (chain_valid[s]),
			.in_item   (chain_item[s]),
			.op        (slot_op[s]),
			.arg       (slot_arg[s]),
			.op_count  (op_count_q),
			.out_valid (chain_valid[s+1]),
			.out_item  (chain_item[s+1])
		);
	end

	assign result_out.valid         = chain_valid[NUM_SLOTS];
	assign result_out.result_value  = chain_item[NUM_SLOTS].val;
	assign result_out.result_length = chain_item[NUM_SLOTS].len;
	assign result_out.error_code    = chain_item[NUM_SLOTS].err;
	assign result_out.error_slot    = chain_item[NUM_SLOTS].err_slot;

endmodule
`default_nettype wire

/* tb/sv/can_payload_value_extractor_tb.sv */
// testbench of the can payload value extractor: directed and random operation chains
`timescale 1ns / 1ps
module can_payload_value_extractor_tb;
	import cpve_pkg::*;

	localparam int NUM_SLOTS = 4;
	localparam int RANDOM_ITEMS = 1700;
	localparam int MAX_REPORTS = 40;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_ARG0 + CFG_IDX_W'(NUM_ARG_REGS);

	typedef enum int {RX_FREE, RX_PATTERN} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	cpve_cfg_if cfg_if ();
	cpve_in_if frame_if ();
	cpve_out_if result_if ();

	can_payload_value_extractor #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.frame_in(frame_if),
		.result_out(result_if)
	);

	// shadow of the chain registers
	logic [2:0] chain_count = '0;
	logic [CODES_W-1:0] chain_codes = '0;
	logic [VAL_W-1:0] chain_args [NUM_ARG_REGS] = '{default: '0};

	item_t pending_results [$];
	item_t want;
	int err_count = 0;
	int burst_left = 1;
	int tx_gap_max = 0;
	int hold_left = 0;
	int rx_tick = 0;
	rx_mode_t rx_mode = RX_FREE;
	logic [15:0] rx_pattern = 16'hFFFF;

	always #4 clk = ~clk;

	function automatic logic [VAL_W-1:0] low_bytes(input int unsigned n);
		if (n >= MAX_BYTES)
			return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic item_t extract_value(input logic [VAL_W-1:0] bytes,
			input logic [LEN_W-1:0] flen);
		item_t r;
		logic [VAL_W-1:0] v;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] m;
		logic [OP_W-1:0] opc;
		int unsigned len;
		int unsigned st;
		int unsigned en;
		int unsigned slots;
		bit stop;
		len = (flen > MAX_BYTES) ? MAX_BYTES : flen;
		v = bytes & low_bytes(len);
		slots = (chain_count > NUM_SLOTS) ? NUM_SLOTS : chain_count;
		r.err = ERR_NONE;
		r.err_slot = '0;
		stop = 1'b0;
		for (int s = 0; s < slots && !stop; s++) begin
			opc = chain_codes[OP_W*s +: OP_W];
			a = chain_args[s];
			m = low_bytes(len);
			if (opc > OP_SHL) begin
				// spare opcodes leave the value alone
			end else if (opc == OP_SELECT) begin
				st = a[7:0];
				en = a[15:8];
				if (st > en || en > len) begin
					r.err = ERR_RANGE;
					r.err_slot = ERR_SLOT_W'(s);
					stop = 1'b1;
				end else begin
					len = en - st;
					v = (v >> (8 * st)) & low_bytes(len);
				end
			end else if (len != 1 && len != 2 && len != 4 && len != 8) begin
				r.err = ERR_WIDTH;
				r.err_slot = ERR_SLOT_W'(s);
				stop = 1'b1;
			end else begin
				case (opc)
					OP_GAIN: v = (v * a) & m;
					OP_OR: v = (v | a) & m;
					OP_AND: v = v & a & m;
					OP_SHR: v = (a >= 8 * len) ? '0 : ((v >> a) & m);
					default: v = (a >= 8 * len) ? '0 : ((v << a) & m);
				endcase
			end
		end
		if (stop) begin
			v = '0;
			len = 0;
		end
		r.val = v;
		r.len = LEN_W'(len);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
			input logic [VAL_W-1:0] exp_val);
		if (err_count < MAX_REPORTS)
			$display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, exp_val);
		err_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", result_if.result_value, '0);
			end else begin
				want = pending_results.pop_front();
				if (result_if.result_value !== want.val)
					report_mismatch("result_value", result_if.result_value, want.val);
				if (result_if.result_length !== want.len)
					report_mismatch("result_length", result_if.result_length, want.len);
				if (result_if.error_code !== want.err)
					report_mismatch("error_code", result_if.error_code, want.err);
				if (result_if.error_slot !== want.err_slot)
					report_mismatch("error_slot", result_if.error_slot, want.err_slot);
			end
		end
	end

	// result receiver with its own stall pattern and long hold-off
	always @(posedge clk) begin
		rx_tick++;
		if (rx_tick % 16 == 0)
			rx_pattern = 16'($urandom) | 16'h0001;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			result_if.ready <= 1'b0;
			hold_left--;
		end else if (rx_mode == RX_FREE) begin
			result_if.ready <= 1'b1;
		end else begin
			result_if.ready <= rx_pattern[0];
			rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
		end
	end

	task automatic send_frame(input logic [VAL_W-1:0] bytes, input logic [LEN_W-1:0] flen);
		int gap;
		frame_if.valid <= 1'b1;
		frame_if.frame_bytes <= bytes;
		frame_if.frame_length <= flen;
		do @(posedge clk); while (frame_if.ready !== 1'b1);
		pending_results.push_back(extract_value(bytes, flen));
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
			if (gap > 0) begin
				frame_if.valid <= 1'b0;
				frame_if.frame_bytes <= {$urandom, $urandom};
				frame_if.frame_length <= LEN_W'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		frame_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		if (idx == REG_OP_COUNT)
			chain_count = data[2:0];
		else if (idx == REG_OP_CODES)
			chain_codes = data[CODES_W-1:0];
		else if (idx >= REG_ARG0 && idx < REG_SPARE)
			chain_args[idx - REG_ARG0] = data;
	endtask

	// only between phases, with nothing in flight
	task automatic load_chain(input logic [2:0] cnt, input logic [CODES_W-1:0] codes,
			input logic [VAL_W-1:0] a0, input logic [VAL_W-1:0] a1,
			input logic [VAL_W-1:0] a2, input logic [VAL_W-1:0] a3, input bit poke_spare);
		drain_results();
		write_reg(REG_OP_COUNT, {61'({$urandom, $urandom}), cnt});
		write_reg(REG_OP_CODES, {52'({$urandom, $urandom}), codes});
		write_reg(REG_ARG0, a0);
		write_reg(REG_ARG0 + 3'd1, a1);
		write_reg(REG_ARG0 + 3'd2, a2);
		write_reg(REG_ARG0 + 3'd3, a3);
		if (poke_spare)
			write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(0, 1)), {$urandom, $urandom});
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [VAL_W-1:0] sel_arg(input logic [7:0] st, input logic [7:0] en);
		return {48'h0, en, st};
	endfunction

	function automatic logic [OP_W-1:0] random_opcode();
		int r;
		r = $urandom_range(0, 25);
		if (r == 24)
			return OP_RSVD6;
		if (r == 25)
			return OP_RSVD7;
		return OP_W'(r % 6);
	endfunction

	function automatic logic [VAL_W-1:0] random_arg(input logic [OP_W-1:0] opc);
		int w;
		int st;
		logic [VAL_W-1:0] a;
		a = {$urandom, $urandom};
		if ($urandom_range(0, 7) == 0)
			return ($urandom_range(0, 1) == 1) ? '1 : '0;
		if (opc == OP_SELECT) begin
			if ($urandom_range(0, 7) == 0) begin
				a[15:0] = {4'h0, 4'($urandom), 4'h0, 4'($urandom)};
			end else begin
				w = 1 << $urandom_range(0, 3);
				st = $urandom_range(0, 8 - w);
				a[7:0] = 8'(st);
				a[15:8] = 8'(st + w);
			end
		end else if (opc == OP_SHR || opc == OP_SHL) begin
			if ($urandom_range(0, 3) != 0)
				a = VAL_W'($urandom_range(0, 70));
		end else if (opc == OP_GAIN && $urandom_range(0, 3) == 0) begin
			a = VAL_W'($urandom_range(0, 300));
		end
		return a;
	endfunction

	task automatic send_random_frame();
		logic [VAL_W-1:0] bytes;
		logic [LEN_W-1:0] flen;
		bytes = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0: bytes = '0;
			1: bytes = '1;
			default: ;
		endcase
		case ($urandom_range(0, 7))
			4: flen = LEN_W'(1 << $urandom_range(0, 2));
			5, 6: flen = LEN_W'($urandom_range(0, 8));
			7: flen = LEN_W'($urandom_range(0, 15));
			default: flen = LEN_W'(MAX_BYTES);
		endcase
		send_frame(bytes, flen);
	endtask

	task automatic test_passthrough();
		send_frame('1, 4'd0);
		send_frame('1, 4'd1);
		send_frame('1, 4'd3);
		send_frame('1, 4'd8);
		send_frame({$urandom, $urandom}, 4'd5);
		send_frame({$urandom, $urandom}, 4'd9);
		send_frame('1, 4'd15);
		send_frame('0, 4'd8);
	endtask

	task automatic test_select_ranges();
		load_chain(3'd1, {OP_SHL, OP_SHL, OP_SHL, OP_SELECT}, sel_arg(8'd2, 8'd6),
			'0, '0, '0, 1'b0);
		send_frame({$urandom, $urandom}, 4'd8);
		send_frame({$urandom, $urandom}, 4'd5);
		send_frame({$urandom, $urandom}, 4'd6);
	endtask

	task automatic test_arith_chain();
		load_chain(3'd4, {OP_SHR, OP_OR, OP_GAIN, OP_SELECT}, sel_arg(8'd1, 8'd5),
			64'h9E37_79B9_7F4A_7C15, 64'hFFFF_0000_0000_F00F, 64'd3, 1'b0);
		send_frame({$urandom, $urandom}, 4'd8);
		send_frame('1, 4'd8);
	endtask

	task automatic test_logic_ops();
		load_chain(3'd4, {OP_RSVD7, OP_SHR, OP_SHL, OP_AND}, '1, 64'd5, 64'd7, '1, 1'b0);
		send_frame({$urandom, $urandom}, 4'd8);
		send_frame({$urandom, $urandom}, 4'd2);
		send_frame({$urandom, $urandom}, 4'd3);
	endtask

	task automatic test_wide_shifts();
		load_chain(3'd2, {OP_SELECT, OP_SELECT, OP_SHL, OP_SHR}, 64'd63, 64'd16, '0, '0, 1'b0);
		send_frame('1, 4'd8);
		send_frame({$urandom, $urandom}, 4'd2);
		send_frame('1, 4'd1);
	endtask

	task automatic test_slot_overflow();
		// count above the slot number, empty selects, spare opcode, width error in the last slot
		load_chain(3'd7, {OP_GAIN, OP_SELECT, OP_RSVD6, OP_SELECT}, sel_arg(8'd3, 8'd3),
			'1, sel_arg(8'd0, 8'd0), 64'd5, 1'b1);
		send_frame({$urandom, $urandom}, 4'd8);
		send_frame({$urandom, $urandom}, 4'd2);
	endtask

	task automatic test_late_errors();
		// start above end in slot two
		load_chain(3'd3, {OP_SHL, OP_SELECT, OP_RSVD6, OP_OR}, '0, '0, sel_arg(8'd5, 8'd3),
			'0, 1'b1);
		send_frame({$urandom, $urandom}, 4'd4);
		send_frame({$urandom, $urandom}, 4'd7);
	endtask

	task automatic test_random_chains();
		logic [OP_W-1:0] ops [NUM_ARG_REGS];
		logic [VAL_W-1:0] args [NUM_ARG_REGS];
		logic [2:0] cnt;
		int sent;
		int phase_items;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			cnt = ($urandom_range(0, 3) != 0) ? 3'd4 : 3'($urandom_range(0, 7));
			for (int i = 0; i < NUM_ARG_REGS; i++) begin
				ops[i] = random_opcode();
				args[i] = random_arg(ops[i]);
			end
			load_chain(cnt, {ops[3], ops[2], ops[1], ops[0]}, args[0], args[1], args[2],
				args[3], $urandom_range(0, 3) == 0);
			rx_mode = ($urandom_range(0, 2) == 0) ? RX_FREE : RX_PATTERN;
			case ($urandom_range(0, 2))
				0: tx_gap_max = 0;
				1: tx_gap_max = 2;
				default: tx_gap_max = 8;
			endcase
			phase_items = $urandom_range(40, 80);
			for (int i = 0; i < phase_items; i++) begin
				send_random_frame();
				if ($urandom_range(0, 199) == 0)
					drain_results();
			end
			sent += phase_items;
		end
	endtask

	task automatic test_backpressure();
		load_chain(3'd4, {OP_SHL, OP_GAIN, OP_AND, OP_SELECT}, sel_arg(8'd0, 8'd4),
			64'h0F0F_F0F0_FFFF_00FF, 64'd3, 64'd2, 1'b0);
		rx_mode = RX_FREE;
		tx_gap_max = 0;
		hold_left = 400;
		repeat (80) send_random_frame();
		drain_results();
		rx_mode = RX_PATTERN;
		tx_gap_max = 4;
		hold_left = 150;
		repeat (40) send_random_frame();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= '0;
		cfg_if.data <= '0;
		frame_if.valid <= 1'b0;
		frame_if.frame_bytes <= '0;
		frame_if.frame_length <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_select_ranges();
		test_arith_chain();
		test_logic_ops();
		test_wide_shifts();
		test_slot_overflow();
		test_late_errors();
		test_random_chains();
		test_backpressure();
		drain_results();
		repeat (3 * NUM_SLOTS + 8) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
